### design/mrr_arb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mrr_arb_pkg;

    localparam int REQUESTERS_DEF = 8;

    localparam int CMD_W  = 2;
    localparam int REQ_W  = 8;
    localparam int PORT_W = 3;
    localparam int IDX_W  = 3;

    localparam logic [CMD_W-1:0] CMD_ARB     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET_HI  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SET_LO  = 2'd2;

    localparam logic MODE_MATRIX = 1'b0;
    localparam logic MODE_RR     = 1'b1;

    // Broadcast from the top level to every cell for the request in flight
    typedef struct packed {
        logic fire;     // request accepted this cycle
        logic mode;     // MODE_MATRIX or MODE_RR
        logic arb;      // arbitrate command
        logic set_hi;   // make target highest, target in range
        logic set_lo;   // make target lowest, target in range
        logic win_any;  // some cell won this cycle
    } t_cell_cmd;

endpackage

`default_nettype wire

### design/mrr_arb_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mrr_arb_req_if;
    import mrr_arb_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [REQ_W-1:0]  request_bits;
    logic [PORT_W-1:0] target_port;

    modport source (output valid, command, request_bits, target_port, input ready);
    modport sink   (input valid, command, request_bits, target_port, output ready);
endinterface

`default_nettype wire

### design/mrr_arb_gnt_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mrr_arb_gnt_if;
    import mrr_arb_pkg::*;

    logic             valid;
    logic             ready;
    logic             grant_valid;
    logic [IDX_W-1:0] grant_index;

    modport source (output valid, grant_valid, grant_index, input ready);
    modport sink   (input valid, grant_valid, grant_index, output ready);
endinterface

`default_nettype wire

### design/mrr_arb_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module mrr_arb_cell #(
    parameter int REQUESTERS = mrr_arb_pkg::REQUESTERS_DEF,
    parameter int IDX        = 0
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire mrr_arb_pkg::t_cell_cmd i_cmd,
    input  wire logic [REQUESTERS-1:0] i_req,
    input  wire logic [REQUESTERS-1:0] i_port_oh,
    input  wire logic [REQUESTERS-1:0] i_win_oh,
    input  wire logic                  i_found,
    output logic                       o_found,
    output logic                       o_mwin,
    input  wire logic                  i_rra,
    output logic                       o_rra,
    input  wire logic                  i_rrb,
    output logic                       o_rrb,
    output logic                       o_rrwin
);
    import mrr_arb_pkg::*;

    localparam int PREV = (IDX + REQUESTERS - 1) % REQUESTERS;
    localparam logic [REQUESTERS-1:0] SELF_OH = REQUESTERS'(1) << IDX;
    // column of the matrix: bit i set when requester i outranks this one
    localparam logic [REQUESTERS-1:0] RST_COL = SELF_OH - REQUESTERS'(1);

    logic [REQUESTERS-1:0] r_col, n_col;
    logic                  r_ptr, n_ptr;
    logic                  own, blocked, free, a_hot;

    always_comb begin
        own     = i_req[IDX];
        blocked = |(i_req & r_col & ~SELF_OH);
        free    = own & ~blocked;
        // lowest unblocked requester wins
        o_mwin  = free & ~i_found;
        o_found = i_found | free;

        // first pass starts at the pointer, second pass wraps from cell 0
        a_hot   = i_rra | r_ptr;
        o_rrwin = (a_hot | i_rrb) & own;
        o_rra   = a_hot & ~own;
        o_rrb   = i_rrb & ~own;
    end

    always_comb begin
        n_col = r_col;
        n_ptr = r_ptr;
        if (i_cmd.fire) begin
            if (i_cmd.mode == MODE_MATRIX) begin
                if (i_cmd.arb && i_cmd.win_any) begin
                    n_col = i_win_oh[IDX] ? ~SELF_OH : (r_col & ~i_win_oh);
                end else if (i_cmd.set_hi) begin
                    n_col = i_port_oh[IDX] ? '0 : (r_col | i_port_oh);
                end else if (i_cmd.set_lo) begin
                    n_col = i_port_oh[IDX] ? ~SELF_OH : (r_col & ~i_port_oh);
                end
            end else begin
                if (i_cmd.arb && i_cmd.win_any) begin
                    n_ptr = i_win_oh[PREV];
                end else if (i_cmd.set_hi) begin
                    n_ptr = i_port_oh[IDX];
                end else if (i_cmd.set_lo) begin
                    n_ptr = i_port_oh[PREV];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= RST_COL;
            r_ptr <= 1'(IDX == 0);
        end else begin
            r_col <= n_col;
            r_ptr <= n_ptr;
        end
    end

endmodule

`default_nettype wire

### design/matrix_or_round_robin_arbiter_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel     Dir  Payload                                   Handshake
// i_req_if    in   command, request_bits, target_port       valid / ready
// o_grant_if  out  grant_valid, grant_index                 valid / ready
// i_cfg_*     in   arbiter_mode (i_cfg_wdata)               write enable, no wait
//
// One request per cycle; the grant is registered and shows the cycle after accept.
// The priority state updates at the accepting edge, so the next request sees it.
// The carry chains through the row of cells set the combinational depth.
// Synchronous active-low reset restores the matrix order and the pointer at 0.
// A held grant stalls input only while o_grant_if.ready is low.

module matrix_or_round_robin_arbiter_top #(
    parameter int REQUESTERS = mrr_arb_pkg::REQUESTERS_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_cfg_we,
    input  wire logic      i_cfg_wdata,
    mrr_arb_req_if.sink    i_req_if,
    mrr_arb_gnt_if.source  o_grant_if
);
    import mrr_arb_pkg::*;

    localparam int EXT_W = (REQUESTERS > REQ_W) ? REQUESTERS : REQ_W;

    logic                  r_mode;
    logic                  r_out_vld;
    logic                  r_grant_valid;
    logic [IDX_W-1:0]      r_grant_index;

    logic                  accept;
    logic                  port_ok;
    logic [EXT_W-1:0]      req_ext;
    logic [REQUESTERS-1:0] req;
    logic [REQUESTERS-1:0] port_oh;
    logic [REQUESTERS-1:0] mwin, rrwin, win_oh;
    logic [REQUESTERS:0]   found_ch, rra_ch, rrb_ch;
    logic [IDX_W-1:0]      win_idx;
    t_cell_cmd             cmd;

    assign i_req_if.ready = !r_out_vld || o_grant_if.ready;
    assign accept         = i_req_if.valid && i_req_if.ready;

    always_comb begin
        req_ext = EXT_W'(i_req_if.request_bits);
        req     = req_ext[REQUESTERS-1:0];
        port_ok = 32'(i_req_if.target_port) < REQUESTERS;
        for (int i = 0; i < REQUESTERS; i++) begin
            port_oh[i] = port_ok && (32'(i_req_if.target_port) == i);
        end

        cmd         = '0;
        cmd.fire    = accept;
        cmd.mode    = r_mode;
        unique case (i_req_if.command)
            CMD_ARB:    cmd.arb    = 1'b1;
            CMD_SET_HI: cmd.set_hi = port_ok;
            CMD_SET_LO: cmd.set_lo = port_ok;
            default:    ;
        endcase

        win_oh      = cmd.arb ? ((r_mode == MODE_RR) ? rrwin : mwin) : '0;
        cmd.win_any = |win_oh;

        win_idx = '0;
        for (int i = 0; i < REQUESTERS; i++) begin
            if (win_oh[i]) begin
                win_idx = win_idx | IDX_W'(i);
            end
        end
    end

    assign found_ch[0] = 1'b0;
    assign rra_ch[0]   = 1'b0;
    assign rrb_ch[0]   = rra_ch[REQUESTERS];

    for (genvar g = 0; g < REQUESTERS; g++) begin : g_cell
        mrr_arb_cell #(
            .REQUESTERS (REQUESTERS),
            .IDX        (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cmd     (cmd),
            .i_req     (req),
            .i_port_oh (port_oh),
            .i_win_oh  (win_oh),
            .i_found   (found_ch[g]),
            .o_found   (found_ch[g+1]),
            .o_mwin    (mwin[g]),
            .i_rra     (rra_ch[g]),
            .o_rra     (rra_ch[g+1]),
            .i_rrb     (rrb_ch[g]),
            .o_rrb     (rrb_ch[g+1]),
            .o_rrwin   (rrwin[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_MATRIX;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (accept) begin
                r_out_vld <= 1'b1;
            end else if (o_grant_if.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_grant_valid <= cmd.win_any;
            r_grant_index <= win_idx;
        end
    end

    assign o_grant_if.valid       = r_out_vld;
    assign o_grant_if.grant_valid = r_grant_valid;
    assign o_grant_if.grant_index = r_grant_index;

endmodule

`default_nettype wire

### test/mrr_arb_grant_checker.sv
`timescale 1ns / 1ps

module mrr_arb_grant_checker
    import mrr_arb_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_cfg_we,
    input  logic   i_cfg_wdata,
    mrr_arb_req_if i_req_mon,
    mrr_arb_gnt_if i_gnt_mon,
    output int     o_fail_count,
    output int     o_pending,
    output int     o_request_count,
    output int     o_grant_count
);

    localparam int NREQ = REQUESTERS_DEF;

    typedef struct packed {
        logic             grant_valid;
        logic [IDX_W-1:0] grant_index;
    } grant_t;

    // beats[i][j] set when requester i has priority over requester j
    logic [NREQ-1:0] beats [NREQ];
    logic [NREQ-1:0] rr_favored;
    logic            arb_mode;
    grant_t          expected_grants [$];
    int              fails;
    int              requests;
    int              grants;

    function automatic grant_t predict_grant(input logic [CMD_W-1:0]  cmd,
                                             input logic [REQ_W-1:0]  reqs,
                                             input logic [PORT_W-1:0] port);
        grant_t g;
        logic   blocked;
        int     start;
        int     r;
        g = '0;
        if (cmd == CMD_ARB && reqs != '0) begin
            if (arb_mode == MODE_MATRIX) begin
                for (int c = 0; c < NREQ; c++) begin
                    if (reqs[c] && !g.grant_valid) begin
                        blocked = 1'b0;
                        for (int i = 0; i < NREQ; i++) begin
                            if (i != c && reqs[i] && beats[i][c])
                                blocked = 1'b1;
                        end
                        if (!blocked) begin
                            // winner drops below everyone else
                            for (int i = 0; i < NREQ; i++) begin
                                if (i != c) begin
                                    beats[c][i] = 1'b0;
                                    beats[i][c] = 1'b1;
                                end
                            end
                            g.grant_valid = 1'b1;
                            g.grant_index = IDX_W'(c);
                        end
                    end
                end
            end else begin
                start = 0;
                for (int k = NREQ - 1; k >= 0; k--) begin
                    if (rr_favored[k])
                        start = k;
                end
                for (int off = 0; off < NREQ; off++) begin
                    r = (start + off) % NREQ;
                    if (reqs[r] && !g.grant_valid) begin
                        rr_favored = NREQ'(1) << ((r + 1) % NREQ);
                        g.grant_valid = 1'b1;
                        g.grant_index = IDX_W'(r);
                    end
                end
            end
        end else if ((cmd == CMD_SET_HI || cmd == CMD_SET_LO) && int'(port) < NREQ) begin
            if (arb_mode == MODE_MATRIX) begin
                for (int i = 0; i < NREQ; i++) begin
                    if (i != int'(port)) begin
                        beats[i][port] = (cmd == CMD_SET_LO);
                        beats[port][i] = (cmd == CMD_SET_HI);
                    end
                end
            end else if (cmd == CMD_SET_HI) begin
                rr_favored = NREQ'(1) << port;
            end else begin
                rr_favored = NREQ'(1) << ((int'(port) + 1) % NREQ);
            end
        end
        return g;
    endfunction

    always @(posedge i_clk) begin
        grant_t want;
        grant_t seen;
        if (!i_rst_n) begin
            for (int i = 0; i < NREQ; i++) begin
                for (int j = 0; j < NREQ; j++)
                    beats[i][j] = (i < j);
            end
            rr_favored = NREQ'(1);
            arb_mode   = MODE_MATRIX;
            expected_grants.delete();
            fails    = 0;
            requests = 0;
            grants   = 0;
        end else begin
            if (i_cfg_we)
                arb_mode = i_cfg_wdata;
            if (i_req_mon.valid && i_req_mon.ready) begin
                // append at the tail
                expected_grants.insert(expected_grants.size(),
                                       predict_grant(i_req_mon.command,
                                                     i_req_mon.request_bits,
                                                     i_req_mon.target_port));
                requests++;
            end
            if (i_gnt_mon.valid && i_gnt_mon.ready) begin
                seen.grant_valid = i_gnt_mon.grant_valid;
                seen.grant_index = i_gnt_mon.grant_index;
                if (expected_grants.size() == 0) begin
                    $error("unexpected grant: grant_valid %0d grant_index %0d",
                           seen.grant_valid, seen.grant_index);
                    fails++;
                end else begin
                    want = expected_grants.pop_front();
                    if (seen.grant_valid !== want.grant_valid) begin
                        $error("grant_valid: expected %0d, actual %0d",
                               want.grant_valid, seen.grant_valid);
                        fails++;
                    end
                    if (seen.grant_index !== want.grant_index) begin
                        $error("grant_index: expected %0d, actual %0d",
                               want.grant_index, seen.grant_index);
                        fails++;
                    end
                    if (want.grant_valid)
                        grants++;
                end
            end
        end
        // publish after the edge so readers never race the update
        o_fail_count    <= fails;
        o_pending       <= expected_grants.size();
        o_request_count <= requests;
        o_grant_count   <= grants;
    end

endmodule

### test/tb_matrix_or_round_robin_arbiter_top.sv
`timescale 1ns / 1ps

module tb_matrix_or_round_robin_arbiter_top;
    import mrr_arb_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int RAND_PHASES      = 6;
    localparam int ITEMS_PER_PHASE  = 65;
    localparam int LONG_HOLD_ITEMS  = 60;
    localparam int LONG_HOLD_CYCLES = 50;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    logic quiet_tail  = 1'b0;
    logic src_calm    = 1'b0;
    logic sink_calm   = 1'b0;
    logic hold_grants = 1'b0;
    int   mode_writes = 0;

    int fail_count;
    int pending;
    int request_count;
    int grant_count;

    mrr_arb_req_if req_if ();
    mrr_arb_gnt_if gnt_if ();

    matrix_or_round_robin_arbiter_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_req_if   (req_if),
        .o_grant_if (gnt_if)
    );

    mrr_arb_grant_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_req_mon      (req_if),
        .i_gnt_mon      (gnt_if),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_request_count(request_count),
        .o_grant_count  (grant_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #400_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic send_request(input logic [CMD_W-1:0]  cmd,
                                input logic [REQ_W-1:0]  reqs,
                                input logic [PORT_W-1:0] port);
        req_if.valid        <= 1'b1;
        req_if.command      <= cmd;
        req_if.request_bits <= reqs;
        req_if.target_port  <= port;
        do @(posedge i_clk); while (!req_if.ready);
        if (!quiet_tail && !src_calm && $urandom_range(0, 3) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    task automatic send_random_request();
        logic [CMD_W-1:0] cmd;
        logic [REQ_W-1:0] reqs;
        int               pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            cmd = CMD_ARB;
        else if (pick < 82)
            cmd = CMD_SET_HI;
        else if (pick < 94)
            cmd = CMD_SET_LO;
        else
            cmd = CMD_UNUSED;
        case ($urandom_range(0, 9))
            0: reqs = '0;
            1: reqs = REQ_W'(1) << $urandom_range(0, REQ_W - 1);
            2: reqs = '1;
            3: reqs = (REQ_W'(1) << $urandom_range(0, REQ_W - 1))
                    | (REQ_W'(1) << $urandom_range(0, REQ_W - 1));
            default: reqs = REQ_W'($urandom);
        endcase
        send_request(cmd, reqs, PORT_W'($urandom));
    endtask

    // wait for every outstanding grant, then let the pipeline settle
    task automatic drain_grants();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic mode);
        drain_grants();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mode;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        mode_writes++;
    endtask

    // grant sink: random stalls, calm stretches, one long hold-off on demand
    initial begin
        gnt_if.ready <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_grants) begin
                gnt_if.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                hold_grants = 1'b0;
            end else if (!quiet_tail && !sink_calm && $urandom_range(0, 2) == 0) begin
                gnt_if.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                gnt_if.ready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            if ($urandom_range(0, 19) == 0)
                sink_calm = !sink_calm;
        end
    end

    initial begin
        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_wdata         <= MODE_MATRIX;
        req_if.valid        <= 1'b0;
        req_if.command      <= CMD_ARB;
        req_if.request_bits <= '0;
        req_if.target_port  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // matrix mode from the reset order
        write_mode(MODE_MATRIX);
        send_request(CMD_ARB,    8'h00, 3'd0);
        send_request(CMD_ARB,    8'hFF, 3'd0);
        send_request(CMD_ARB,    8'hFF, 3'd7);
        send_request(CMD_ARB,    8'h81, 3'd0);
        send_request(CMD_SET_HI, 8'h00, 3'd0);
        send_request(CMD_ARB,    8'h81, 3'd0);
        send_request(CMD_SET_LO, 8'hFF, 3'd0);
        send_request(CMD_ARB,    8'h01, 3'd0);
        send_request(CMD_UNUSED, 8'hFF, 3'd5);
        send_request(CMD_SET_HI, 8'h00, 3'd7);
        send_request(CMD_ARB,    8'hFF, 3'd0);
        send_request(CMD_SET_LO, 8'hFF, 3'd7);

        // round-robin: wrap, pointer moves from both set commands
        write_mode(MODE_RR);
        send_request(CMD_ARB,    8'h00, 3'd0);
        send_request(CMD_ARB,    8'hFF, 3'd0);
        send_request(CMD_ARB,    8'h80, 3'd0);
        send_request(CMD_ARB,    8'h01, 3'd0);
        send_request(CMD_SET_HI, 8'h00, 3'd7);
        send_request(CMD_ARB,    8'hFF, 3'd0);
        send_request(CMD_SET_LO, 8'h00, 3'd7);
        send_request(CMD_ARB,    8'h81, 3'd0);
        send_request(CMD_SET_LO, 8'h00, 3'd3);
        send_request(CMD_ARB,    8'h0F, 3'd0);
        send_request(CMD_UNUSED, 8'hFF, 3'd0);
        send_request(CMD_SET_HI, 8'h00, 3'd0);
        send_request(CMD_ARB,    8'h80, 3'd0);

        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            write_mode(phase % 2 == 1 ? MODE_RR : MODE_MATRIX);
            quiet_tail = (phase == RAND_PHASES - 1);
            if (phase == 1) begin
                // keep offering back to back while the sink holds off
                hold_grants = 1'b1;
                src_calm    = 1'b1;
                repeat (LONG_HOLD_ITEMS) send_random_request();
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (phase == 2 && n == ITEMS_PER_PHASE / 2)
                    drain_grants();
                send_random_request();
                if ($urandom_range(0, 15) == 0)
                    src_calm = !src_calm;
            end
        end

        drain_grants();
        repeat (8) @(posedge i_clk);
        $display("Run: %0d requests, %0d grants, %0d mode writes over matrix and round-robin",
                 request_count, grant_count, mode_writes);
        $display("Random stalls on both sides, one long grant hold-off, drained pauses");
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### sim.f
design/mrr_arb_pkg.sv
design/mrr_arb_req_if.sv
design/mrr_arb_gnt_if.sv
design/mrr_arb_cell.sv
design/matrix_or_round_robin_arbiter_top.sv
test/mrr_arb_grant_checker.sv
test/tb_matrix_or_round_robin_arbiter_top.sv
